>>> sv/ldts_pkg.sv
// Package for the log-domain topic softmax block: widths, request codes,
// controller states, the command struct and the correction table.
`default_nettype none
package ldts_pkg;
  localparam int unsigned Topics     = 16;
  localparam int unsigned VocabWords = 4096;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ValW       = 24;
  localparam int unsigned TopicW     = 4;
  localparam int unsigned WordW      = 12;
  localparam int unsigned BetaAw     = WordW + TopicW;
  localparam int unsigned BetaDepth  = VocabWords * Topics;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [1:0] {
    REQ_THETA = 2'd0,
    REQ_BETA  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FOLD,
    ST_EMIT,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic              wr_theta;
    logic              wr_beta;
    logic              rd_en;
    logic [TopicW-1:0] rd_topic;
    logic              fold;
    logic              fold_first;
    logic [TopicW-1:0] fold_topic;
    logic              emit;
    logic [TopicW-1:0] emit_topic;
  } cmd_t;

  function automatic val_t sat24(input logic signed [ValW+1:0] v);
    if (v > $signed({2'b00, 1'b0, {(ValW-1){1'b1}}})) return {1'b0, {(ValW-1){1'b1}}};
    if (v < $signed({2'b11, 1'b1, {(ValW-1){1'b0}}})) return {1'b1, {(ValW-1){1'b0}}};
    return v[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] corr_q24(input logic [3:0] idx);
    case (idx)
      4'd0:    return 24'd9662670;
      4'd1:    return 24'd6490618;
      4'd2:    return 24'd4226667;
      4'd3:    return 24'd2688113;
      4'd4:    return 24'd1681190;
      4'd5:    return 24'd1039641;
      4'd6:    return 24'd638227;
      4'd7:    return 24'd389995;
      4'd8:    return 24'd237624;
      4'd9:    return 24'd144524;
      4'd10:   return 24'd87809;
      4'd11:   return 24'd53313;
      4'd12:   return 24'd32357;
      4'd13:   return 24'd19633;
      4'd14:   return 24'd11912;
      default: return 24'd7224;
    endcase
  endfunction

  // log(1+exp(-d)) for d >= 0, FracBits fraction bits
  function automatic val_t corr_lookup(input logic [ValW:0] d);
    logic [ValW:0]   idx;
    logic [ValW+1:0] v;
    idx = d >> (FracBits - 1);
    if (idx >= (ValW+1)'(16)) return '0;
    v = {2'b00, corr_q24(idx[3:0])};
    if (FracBits < 24) v = (v + ((ValW+2)'(1) << (23 - FracBits))) >> (24 - FracBits);
    return v[ValW-1:0];
  endfunction
endpackage
`default_nettype wire

>>> sv/ldts_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ldts_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/ldts_datapath.sv
// Datapath: theta and beta stores, logit buffer, log-sum-exp accumulator,
// output register. Depends on ldts_pkg and ldts_ram.
`default_nettype none
module ldts_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ldts_pkg::cmd_t                cmd_i,
  input  wire logic [ldts_pkg::WordW-1:0]    word_i,
  input  wire logic [ldts_pkg::TopicW-1:0]   topic_i,
  input  wire logic [ldts_pkg::ValW-1:0]     value_i,
  output logic      [ldts_pkg::TopicW-1:0]   topic_o,
  output logic      [ldts_pkg::ValW-1:0]     resp_o
);
  import ldts_pkg::*;

  logic [ValW-1:0] theta_rd, beta_rd;
  val_t            logit_q [Topics];
  val_t            lse_q, lse_d, sum;
  val_t            hi;
  logic [ValW:0]   dif;

  ldts_ram #(.Width(ValW), .Depth(Topics)) u_theta (
    .clk_i, .we_i(cmd_i.wr_theta), .waddr_i(topic_i), .wdata_i(value_i),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.rd_topic), .rdata_o(theta_rd));

  ldts_ram #(.Width(ValW), .Depth(BetaDepth)) u_beta (
    .clk_i, .we_i(cmd_i.wr_beta), .waddr_i({word_i, topic_i}), .wdata_i(value_i),
    .re_i(cmd_i.rd_en), .raddr_i({word_i, cmd_i.rd_topic}), .rdata_o(beta_rd));

  assign sum = sat24({{2{theta_rd[ValW-1]}}, theta_rd} + {{2{beta_rd[ValW-1]}}, beta_rd});

  always_comb begin
    if (lse_q > sum) begin
      hi  = lse_q;
      dif = {lse_q[ValW-1], lse_q} - {sum[ValW-1], sum};
    end else begin
      hi  = sum;
      dif = {sum[ValW-1], sum} - {lse_q[ValW-1], lse_q};
    end
    lse_d = sat24({{2{hi[ValW-1]}}, hi} + {2'b00, corr_lookup(dif)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lse_q <= '0;
      for (int i = 0; i < Topics; i++) logit_q[i] <= '0;
    end else if (cmd_i.fold) begin
      logit_q[cmd_i.fold_topic] <= sum;
      lse_q <= cmd_i.fold_first ? sum : lse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      topic_o <= cmd_i.emit_topic;
      resp_o  <= sat24({{2{logit_q[cmd_i.emit_topic][ValW-1]}}, logit_q[cmd_i.emit_topic]}
                       - {{2{lse_q[ValW-1]}}, lse_q});
    end
  end
endmodule
`default_nettype wire

>>> sv/ldts_ctrl.sv
// Controller FSM: decodes requests, sequences read/fold and emit passes,
// drives the output handshake. Depends on ldts_pkg.
`default_nettype none
module ldts_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  req_i,
  input  wire logic [ldts_pkg::WordW-1:0]  word_i,
  output ldts_pkg::cmd_t                   cmd_o,
  output logic [ldts_pkg::WordW-1:0]       word_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_last_o
);
  import ldts_pkg::*;

  state_e            state_q, state_d;
  logic [TopicW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0]  word_q, word_d;
  logic              acc;
  logic              last_q, last_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign word_o      = (state_q == ST_IDLE) ? word_i : word_q;
  assign out_valid_o = (state_q == ST_HOLD);
  assign out_last_o  = last_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.rd_topic   = cnt_q;
    cmd_o.fold_topic = cnt_q;
    cmd_o.emit_topic = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_e'(req_i))
            REQ_THETA: cmd_o.wr_theta = 1'b1;
            REQ_BETA:  cmd_o.wr_beta = (32'(word_i) < VocabWords);
            REQ_QUERY: begin
              if (32'(word_i) < VocabWords) begin
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_topic = '0;
                word_d  = word_i;
                cnt_d   = '0;
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // read data for cnt_q available; fold it, read next unless this is the last topic
        cmd_o.fold       = 1'b1;
        cmd_o.fold_first = (cnt_q == '0);
        if (cnt_q == TopicW'(Topics - 1)) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_topic = cnt_q + 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        last_d     = (cnt_q == TopicW'(Topics - 1));
        state_d    = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i) begin
          if (last_q) state_d = ST_IDLE;
          else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      word_q  <= word_d;
    end
  end
endmodule
`default_nettype wire

>>> sv/log_domain_topic_softmax.sv
// Top level of the log-domain topic softmax block.
// Depends on ldts_pkg, ldts_ctrl, ldts_datapath.
// Loads (theta or beta) are written when accepted. A query reads one topic
// per cycle from the theta and beta RAMs and folds it into the log-sum-exp,
// then emits the results in topic order, holding each until the sink is
// ready; no input is taken meanwhile. Results carry topic in tuser, last
// in tlast. Reading a never-written store entry gives undefined results.
`default_nettype none
module log_domain_topic_softmax (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] req_type, [13:2] word_id, [17:14] topic_id, [41:18] load_value
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] log_resp
  output logic [23:0]      m_axis_tdata,
  // [3:0] topic_out
  output logic [3:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import ldts_pkg::*;

  cmd_t             cmd;
  logic [WordW-1:0] word;

  ldts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .req_i(s_axis_tdata[1:0]), .word_i(s_axis_tdata[13:2]),
    .cmd_o(cmd), .word_o(word),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_o(m_axis_tlast));

  ldts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .word_i(word),
    .topic_i(s_axis_tdata[17:14]), .value_i(s_axis_tdata[41:18]),
    .topic_o(m_axis_tuser), .resp_o(m_axis_tdata));
endmodule
`default_nettype wire

>>> sv/ldts_checker.sv
// Port-level checker for log_domain_topic_softmax, bound to the top level.
// No package dependency.
`default_nettype none
module ldts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [3:0]  m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic [23:0] m_axis_tdata
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emit");
  a_last_topic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 4'd15)))
    else $error("tlast mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
  a_next_topic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> ##1
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser, 2) + 4'd1))
    else $error("topic order");
endmodule

bind log_domain_topic_softmax ldts_checker u_chk (.*);
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for log_domain_topic_softmax: loads topic weights and word-topic
// entries, queries words and checks every normalized result against an
// in-bench log-sum-exp predictor. Depends on ldts_pkg and the block's RTL.
`default_nettype none
module tb;
  import ldts_pkg::*;

  typedef struct packed {
    logic [3:0]  topic;
    logic [23:0] resp;
    logic        last;
  } resp_t;

  class resp_scoreboard;
    logic signed [23:0] theta [Topics];
    logic signed [23:0] beta [int];
    resp_t              pending [$];
    int                 errors;

    function automatic logic signed [23:0] clamp(input logic signed [26:0] v);
      if (v > 27'sd8388607) return 24'sh7fffff;
      if (v < -27'sd8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function automatic logic signed [23:0] soft_corr(input logic [24:0] d);
      logic [24:0] idx;
      logic [26:0] v;
      int          tab [16];
      tab = '{9662670, 6490618, 4226667, 2688113, 1681190, 1039641, 638227,
              389995, 237624, 144524, 87809, 53313, 32357, 19633, 11912, 7224};
      idx = d >> (FracBits - 1);
      if (idx >= 16) return '0;
      v = 27'(tab[idx[3:0]]);
      v = (v + (27'd1 << (23 - FracBits))) >> (24 - FracBits);
      return v[23:0];
    endfunction

    function void note_item(input req_e req, input logic [11:0] word,
                            input logic [3:0] topic, input logic signed [23:0] val);
      logic signed [23:0] logit [Topics];
      logic signed [23:0] total;
      logic signed [23:0] hi;
      logic signed [24:0] d;
      resp_t              r;
      if (req == REQ_THETA) theta[topic] = val;
      else if (req == REQ_BETA) beta[{word, topic}] = val;
      else if (req == REQ_QUERY) begin
        for (int k = 0; k < Topics; k++) begin
          logit[k] = clamp(27'(theta[k]) + 27'(beta[{word, 4'(k)}]));
          if (k == 0) total = logit[k];
          else begin
            hi = (total > logit[k]) ? total : logit[k];
            d = (total > logit[k]) ? 25'(total) - 25'(logit[k])
                                   : 25'(logit[k]) - 25'(total);
            total = clamp(27'(hi) + 27'(soft_corr(d)));
          end
        end
        for (int k = 0; k < Topics; k++) begin
          r.topic = 4'(k);
          r.resp = clamp(27'(logit[k]) - 27'(total));
          r.last = (k == Topics - 1);
          pending.push_back(r);
        end
      end
    endfunction

    function void check_result(input resp_t got);
      resp_t want;
      if (pending.size() == 0) begin
        $error("unexpected result topic %0d", got.topic);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.topic != want.topic) begin
        $error("topic_out: expected %0d, got %0d", want.topic, got.topic); errors++;
      end
      if (got.resp != want.resp) begin
        $error("log_resp: expected %0d, got %0d", $signed(want.resp), $signed(got.resp));
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  log_domain_topic_softmax u_top (.*);

  resp_scoreboard sb;
  int  send_idle, recv_idle;
  bit  hold_sink;
  bit  word_ready [int];
  int  loaded_words [$];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high after an item is taken; callers drop it before idling
  task automatic send_item(input req_e req, input logic [11:0] word,
                           input logic [3:0] topic, input logic signed [23:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, val, topic, word, 2'(req)};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(req, word, topic, val);
  endtask

  task automatic load_word(input logic [11:0] word, input bit extreme);
    logic signed [23:0] v;
    for (int k = 0; k < Topics; k++) begin
      v = extreme ? ((k % 2) ? 24'sh7fffff : 24'sh800000) : 24'($urandom);
      if (!extreme && $urandom_range(1)) v = 24'(int'($urandom_range(2000000)) - 1000000);
      send_item(REQ_BETA, word, 4'(k), v);
    end
    if (!word_ready.exists(word)) loaded_words.push_back(word);
    word_ready[word] = 1;
  endtask

  task automatic random_item();
    int r;
    logic [11:0] w;
    r = $urandom_range(99);
    if (r < 45) send_item(REQ_QUERY, 12'(loaded_words[$urandom_range(loaded_words.size()-1)]),
                          4'($urandom), 24'($urandom));
    else if (r < 55) send_item(REQ_THETA, 12'($urandom), 4'($urandom), 24'($urandom));
    else if (r < 80) begin
      w = 12'(loaded_words[$urandom_range(loaded_words.size()-1)]);
      send_item(REQ_BETA, w, 4'($urandom), 24'($urandom));
    end else if (r < 88) load_word(12'($urandom), 0);
    else send_item(REQ_NONE, 12'($urandom), 4'($urandom), 24'($urandom));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{m_axis_tuser, m_axis_tdata, m_axis_tlast});
    m_axis_tready <= !hold_sink && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    sb = new();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_sink = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: all thetas, extreme and zero words, saturation, ignored items
    for (int k = 0; k < Topics; k++)
      send_item(REQ_THETA, 12'd0, 4'(k), (k == 0) ? 24'sh7fffff : 24'sh0);
    load_word(12'd4095, 1);
    send_item(REQ_QUERY, 12'd4095, 4'd15, 24'sh800000);
    send_item(REQ_NONE, 12'd4095, 4'd15, 24'sh7fffff);
    send_item(REQ_QUERY, 12'd4095, 4'd0, 24'sh0);
    s_axis_tvalid <= 0;
    drain();

    for (int k = 0; k < Topics; k++) send_item(REQ_THETA, 12'd0, 4'(k), 24'sh800000);
    load_word(12'd0, 1);
    send_item(REQ_QUERY, 12'd0, 4'd0, 24'sh0);
    for (int k = 0; k < Topics; k++) send_item(REQ_THETA, 12'hfff, 4'(k), 24'($urandom));

    // long sink hold-off so the block backs up
    fork
      begin
        hold_sink = 1;
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      begin
        for (int i = 0; i < 6; i++)
          send_item(REQ_QUERY, (i % 2) ? 12'd0 : 12'd4095, 4'($urandom), 24'($urandom));
        s_axis_tvalid <= 0;
      end
    join
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 13 : (phase == 1) ? 75 : 0;
      recv_idle = (phase == 0) ? 75 : (phase == 1) ? 13 : 0;
      for (int i = 0; i < 40; i++) random_item();
      s_axis_tvalid <= 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
